// ----- design/skvt_pkg.sv -----
// Shared types, codes and default sizes for the small key/value table.
package skvt_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int KEY_BITS_DEF    = 16;
	localparam int VALUE_BITS_DEF  = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_ERASE  = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_COUNT  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUP_KEY   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CMP  = 2'd1,
		S_RES  = 2'd2
	} state_t;

	// Per-cell strobes from the controller.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic shf;
	} cell_ctl_t;

endpackage

// ----- design/skvt_req_if.sv -----
// Request channel: kind, key and value with a valid/ready handshake.
interface skvt_req_if import skvt_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output kind, output key, output value, input ready);
	modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

// ----- design/skvt_rsp_if.sv -----
// Response channel: status, found value, match count and occupancy.
interface skvt_rsp_if import skvt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int CNT_BITS   = $clog2(TABLE_DEPTH_DEF + 1)
) ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [VALUE_BITS-1:0] found_value;
	logic [CNT_BITS-1:0]   match_count;
	logic [CNT_BITS-1:0]   entries_used;

	modport source (output valid, output status, output found_value, output match_count,
		output entries_used, input ready);
	modport sink   (input valid, input status, input found_value, input match_count,
		input entries_used, output ready);
endinterface

// ----- design/skvt_cell.sv -----
// One table cell: holds a key/value pair, compares it and shifts it down the row.
module skvt_cell import skvt_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic                  occupied,
	input  logic [KEY_BITS-1:0]   req_key,
	input  logic [VALUE_BITS-1:0] req_value,
	input  logic [KEY_BITS-1:0]   nxt_key,
	input  logic [VALUE_BITS-1:0] nxt_value,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] value,
	output logic                  key_hit,
	output logic                  val_hit
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  key_hit_q;
	logic                  val_hit_q;

	// Load a new pair on insert, take the upper neighbor's pair on erase
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			key_q   <= req_key;
			value_q <= req_value;
		end else if (ctl.shf) begin
			key_q   <= nxt_key;
			value_q <= nxt_value;
		end
	end

	// Register the match flags; an empty cell never matches
	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			key_hit_q <= occupied && (key_q == req_key);
			val_hit_q <= occupied && (value_q == req_value);
		end
	end

	assign key     = key_q;
	assign value   = value_q;
	assign key_hit = key_hit_q;
	assign val_hit = val_hit_q;

endmodule

// ----- design/small_key_value_table.sv -----
// Top level of the small key/value table: controller, cell row and result register.
//
// A packed table of up to TABLE_DEPTH key/value pairs held in a row of cells. Each
// request word (insert, erase, lookup, count) is accepted in the idle state; in the
// compare state every cell compares its pair against the request and registers the
// match; the resolve state resolves the matches, updates the row (an erase moves
// every pair above the hit down one cell) and loads the result register.
// A new request is taken while an earlier result still waits in the result
// register; the resolve cycle holds until that register is free. Insert into a full
// table answers status 3 before the duplicate check. There is no clearing pass:
// entries at or above the fill count never match a request.
module small_key_value_table import skvt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF,
	parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	skvt_req_if.sink      req,
	skvt_rsp_if.source    rsp
);

	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

	state_t                state_q, state_d;
	logic [1:0]            req_kind_q;
	logic [KEY_BITS-1:0]   req_key_q;
	logic [VALUE_BITS-1:0] req_value_q;
	logic [CNT_BITS-1:0]   count_q, count_d;

	logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] key_hit, val_hit;

	logic                  in_ready, cmp_go, commit, ins_ok, shf_ok, ins_go, shf_go;
	logic                  any_hit;
	logic [IDX_BITS-1:0]   hit_idx;
	logic [VALUE_BITS-1:0] found_v;
	logic [CNT_BITS-1:0]   match_n;

	status_t               status_d, status_q;
	logic [VALUE_BITS-1:0] found_d, found_q;
	logic [CNT_BITS-1:0]   match_d, match_q, used_q;
	logic                  out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence each word through compare and resolve
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmp_go   = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) state_d = S_CMP;
			end
			S_CMP: begin
				cmp_go  = 1'b1;
				state_d = S_RES;
			end
			S_RES: begin
				if (!out_valid_q || rsp.ready) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req.ready = in_ready;

	// Capture the request word
	always_ff @(posedge clk) begin
		if (req.valid && in_ready) begin
			req_kind_q  <= req.kind;
			req_key_q   <= req.key;
			req_value_q <= req.value;
		end
	end

	// Row of cells; the top cell has no upper neighbor and keeps its own pair
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_ctl_t             ctl;
		logic [KEY_BITS-1:0]   nxt_key;
		logic [VALUE_BITS-1:0] nxt_value;

		assign ctl.cmp = cmp_go;
		assign ctl.ins = ins_go && (count_q == CNT_BITS'(i));
		assign ctl.shf = shf_go && (IDX_BITS'(i) >= hit_idx);

		if (i == TABLE_DEPTH - 1) begin : g_top
			assign nxt_key   = cell_key[i];
			assign nxt_value = cell_value[i];
		end else begin : g_mid
			assign nxt_key   = cell_key[i+1];
			assign nxt_value = cell_value[i+1];
		end

		skvt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CNT_BITS'(i) < count_q),
			.req_key   (req_key_q),
			.req_value (req_value_q),
			.nxt_key   (nxt_key),
			.nxt_value (nxt_value),
			.key       (cell_key[i]),
			.value     (cell_value[i]),
			.key_hit   (key_hit[i]),
			.val_hit   (val_hit[i])
		);
	end

	// Gather the hits: keys are unique, so at most one key hit to encode
	always_comb begin
		any_hit = |key_hit;
		hit_idx = '0;
		found_v = '0;
		match_n = CNT_BITS'($countones(val_hit));
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (key_hit[i]) begin
				hit_idx = hit_idx | IDX_BITS'(i);
				found_v = found_v | cell_value[i];
			end
		end
	end

	// Decide the outcome of the held request
	always_comb begin
		status_d = ST_OK;
		found_d  = '0;
		match_d  = '0;
		ins_ok   = 1'b0;
		shf_ok   = 1'b0;
		count_d  = count_q;
		unique case (req_kind_q)
			KIND_INSERT: begin
				if (count_q == CNT_BITS'(TABLE_DEPTH)) begin
					status_d = ST_FULL;
				end else if (any_hit) begin
					status_d = ST_DUP_KEY;
				end else begin
					ins_ok  = 1'b1;
					count_d = count_q + CNT_BITS'(1);
				end
			end
			KIND_ERASE: begin
				if (!any_hit) begin
					status_d = ST_NOT_FOUND;
				end else begin
					shf_ok  = 1'b1;
					count_d = count_q - CNT_BITS'(1);
				end
			end
			KIND_LOOKUP: begin
				if (!any_hit) status_d = ST_NOT_FOUND;
				else found_d = found_v;
			end
			KIND_COUNT: begin
				match_d = match_n;
			end
			default: status_d = ST_OK;
		endcase
	end

	assign ins_go = commit && ins_ok;
	assign shf_go = commit && shf_ok;

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_d;
		end
	end

	// Result register: load on resolve, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			found_q  <= found_d;
			match_q  <= match_d;
			used_q   <= count_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.found_value  = found_q;
	assign rsp.match_count  = match_q;
	assign rsp.entries_used = used_q;

	// The fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(TABLE_DEPTH))
		else $error("fill count above capacity");

	// Keys stay unique, so resolve never sees two key hits
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RES |-> $onehot0(key_hit))
		else $error("more than one key hit");

	// A successful erase shrinks the table by one
	a_erase_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		shf_go |=> count_q == $past(count_q) - CNT_BITS'(1))
		else $error("erase did not shrink table");

	// A resolved word always lands in the result register
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && used_q == count_q)
		else $error("result not loaded after resolve");

endmodule
